>>> rtl/psec_pkg.sv
package psec_pkg;

  localparam int BITS_PER_ITEM = 8;

  localparam int REG_W     = 64;
  localparam int LEN_W     = 7;
  localparam int SCORE_W   = 9;
  localparam int CNT48_W   = 48;
  localparam int CNT32_W   = 32;
  localparam int BYTE_CNT_W = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = REG_W;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED = 3'd0,
    CFG_MASK = 3'd1,
    CFG_TAPS = 3'd2,
    CFG_LEN  = 3'd3
  } cfg_index_t;

  localparam logic [REG_W-1:0] SEED_RST = 64'd1;
  localparam logic [REG_W-1:0] MASK_RST = 64'd127;
  localparam logic [REG_W-1:0] TAPS_RST = 64'd96;
  localparam logic [LEN_W-1:0] LEN_RST  = 7'd7;

  // result tdata layout, lowest bit first
  localparam int OUT_LOCK_LSB  = 0;
  localparam int OUT_BERR_LSB  = OUT_LOCK_LSB + 1;
  localparam int OUT_TBITS_LSB = OUT_BERR_LSB + BYTE_CNT_W;
  localparam int OUT_LBITS_LSB = OUT_TBITS_LSB + CNT48_W;
  localparam int OUT_ERRS_LSB  = OUT_LBITS_LSB + CNT48_W;
  localparam int OUT_SLIP_LSB  = OUT_ERRS_LSB + CNT48_W;
  localparam int OUT_USED_W    = OUT_SLIP_LSB + CNT32_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  localparam int IN_DATA_W = BITS_PER_ITEM;

endpackage

>>> rtl/prbs_sync_error_checker_unit.sv
// PRBS bit error checker with a programmable self-synchronizing LFSR. Each received
// byte (in_tdata) is checked MSB first against a prediction formed as the parity of
// the shift register bits selected by feedback_taps. While unlocked the received bits
// feed the register and a run of more than 4*register_length matches declares lock;
// while locked the predicted bits feed the register and a leaky error score (down on
// a match, up on a mismatch) drops lock and counts a slip once it exceeds the same
// threshold. in_tuser set clears the statistics, lock and score before its byte; the
// shift register is kept. in_tlast is echoed on out_tlast. Every byte yields one
// result transfer carrying the lock state, the byte's error bits and the saturating
// bit, locked-bit, error and slip counters. Timing: one input register and one result
// register with all eight bit steps unrolled between them, so a byte is accepted every
// cycle while out_tready stays high; the eight chained bit steps, each a parity tree
// feeding the next shift, set the clock period rather than the throughput. The user
// must write configuration through cfg_we/cfg_index/cfg_wdata only while no byte is
// in flight; the block does not enforce this. Writing seed_value reloads the shift
// register at once, and indexes above 3 are ignored.
module prbs_sync_error_checker_unit
  import psec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // rx_byte
  input  logic                  in_tuser,   // clear_stats
  input  logic                  in_tlast,   // end_of_buffer

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // is_locked, byte_error_bits, total_bits, locked_bits, total_errors, slip_count, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // end_of_buffer_out

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [REG_W-1:0] mask_r;
  logic [REG_W-1:0] taps_r;
  logic [LEN_W-1:0] len_r;

  // checker state
  logic [REG_W-1:0]   shift_r,  shift_nxt;
  logic               lock_r,   lock_nxt;
  logic [SCORE_W-1:0] score_r,  score_nxt;
  logic [CNT48_W-1:0] tbits_r,  tbits_nxt;
  logic [CNT48_W-1:0] lbits_r,  lbits_nxt;
  logic [CNT48_W-1:0] errs_r,   errs_nxt;
  logic [CNT32_W-1:0] slips_r,  slips_nxt;

  // input stage
  logic                 in_valid_r;
  logic [IN_DATA_W-1:0] rx_r;
  logic                 clr_r;
  logic                 eob_r;

  // result stage
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r;

  logic in_xfer;
  logic advance;   // input stage moves into the result stage

  logic [BYTE_CNT_W-1:0] byte_errs;
  logic [BYTE_CNT_W-1:0] byte_locked;
  logic [BYTE_CNT_W-1:0] byte_slips;

  function automatic logic [CNT48_W-1:0] sat_add48(logic [CNT48_W-1:0] v,
                                                   logic [BYTE_CNT_W-1:0] inc);
    logic [CNT48_W:0] sum;
    sum = {1'b0, v} + {{(CNT48_W+1-BYTE_CNT_W){1'b0}}, inc};
    return sum[CNT48_W] ? {CNT48_W{1'b1}} : sum[CNT48_W-1:0];
  endfunction

  function automatic logic [CNT32_W-1:0] sat_add32(logic [CNT32_W-1:0] v,
                                                   logic [BYTE_CNT_W-1:0] inc);
    logic [CNT32_W:0] sum;
    sum = {1'b0, v} + {{(CNT32_W+1-BYTE_CNT_W){1'b0}}, inc};
    return sum[CNT32_W] ? {CNT32_W{1'b1}} : sum[CNT32_W-1:0];
  endfunction

  // handshake: input stage is free or drains this cycle
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // eight bit steps of one byte, MSB first
  always_comb begin
    logic [REG_W-1:0]      s;
    logic                  lk;
    logic [SCORE_W-1:0]    sc;
    logic [SCORE_W-1:0]    thr;
    logic [IN_DATA_W-1:0]  rx_sh;
    logic                  bit_in;
    logic                  pred;
    logic [BYTE_CNT_W-1:0] n_err;
    logic [BYTE_CNT_W-1:0] n_lck;
    logic [BYTE_CNT_W-1:0] n_slp;
    logic [CNT48_W-1:0]    base_t;
    logic [CNT48_W-1:0]    base_l;
    logic [CNT48_W-1:0]    base_e;
    logic [CNT32_W-1:0]    base_s;

    thr   = {len_r, 2'b00};
    s     = shift_r;
    lk    = clr_r ? 1'b0 : lock_r;
    sc    = clr_r ? '0 : score_r;
    rx_sh = rx_r;
    n_err = '0;
    n_lck = '0;
    n_slp = '0;

    for (int i = 0; i < BITS_PER_ITEM; i++) begin
      bit_in = rx_sh[IN_DATA_W-1];
      rx_sh  = {rx_sh[IN_DATA_W-2:0], 1'b0};
      pred   = ^(s & taps_r);
      s      = {s[REG_W-2:0], (lk ? pred : bit_in)} & mask_r;
      if (lk) begin
        n_lck = n_lck + 4'd1;
        if (bit_in == pred) begin
          if (sc != '0) sc = sc - 9'd1;
        end else begin
          sc    = sc + 9'd1;
          n_err = n_err + 4'd1;
        end
        if (sc > thr) begin
          // error score ran over: lock lost
          sc    = '0;
          lk    = 1'b0;
          n_slp = n_slp + 4'd1;
        end
      end else begin
        sc = (bit_in == pred) ? sc + 9'd1 : '0;
        if (sc > thr) begin
          sc = '0;
          lk = 1'b1;
        end
      end
    end

    base_t = clr_r ? '0 : tbits_r;
    base_l = clr_r ? '0 : lbits_r;
    base_e = clr_r ? '0 : errs_r;
    base_s = clr_r ? '0 : slips_r;

    byte_errs   = n_err;
    byte_locked = n_lck;
    byte_slips  = n_slp;

    shift_nxt = s;
    lock_nxt  = lk;
    score_nxt = sc;
    tbits_nxt = sat_add48(base_t, BYTE_CNT_W'(BITS_PER_ITEM));
    lbits_nxt = sat_add48(base_l, byte_locked);
    errs_nxt  = sat_add48(base_e, byte_errs);
    slips_nxt = sat_add32(base_s, byte_slips);

    out_data_nxt = '0;
    out_data_nxt[OUT_LOCK_LSB]                         = lock_nxt;
    out_data_nxt[OUT_BERR_LSB  +: BYTE_CNT_W]          = byte_errs;
    out_data_nxt[OUT_TBITS_LSB +: CNT48_W]             = tbits_nxt;
    out_data_nxt[OUT_LBITS_LSB +: CNT48_W]             = lbits_nxt;
    out_data_nxt[OUT_ERRS_LSB  +: CNT48_W]             = errs_nxt;
    out_data_nxt[OUT_SLIP_LSB  +: CNT32_W]             = slips_nxt;
  end

  // configuration and checker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= MASK_RST;
      taps_r  <= TAPS_RST;
      len_r   <= LEN_RST;
      shift_r <= SEED_RST;
      lock_r  <= 1'b0;
      score_r <= '0;
      tbits_r <= '0;
      lbits_r <= '0;
      errs_r  <= '0;
      slips_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED: shift_r <= cfg_wdata;
        CFG_MASK: mask_r  <= cfg_wdata;
        CFG_TAPS: taps_r  <= cfg_wdata;
        CFG_LEN:  len_r   <= cfg_wdata[LEN_W-1:0];
        default:  ;
      endcase
    end else if (advance) begin
      shift_r <= shift_nxt;
      lock_r  <= lock_nxt;
      score_r <= score_nxt;
      tbits_r <= tbits_nxt;
      lbits_r <= lbits_nxt;
      errs_r  <= errs_nxt;
      slips_r <= slips_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rx_r  <= in_tdata;
      clr_r <= in_tuser;
      eob_r <= in_tlast;
    end
  end

  // result stage, holds until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
      out_last_r <= eob_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/psec_port_checker.sv
module psec_port_checker
  import psec_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic [BYTE_CNT_W-1:0] berr;
  logic [CNT48_W-1:0]    tbits;
  logic [CNT48_W-1:0]    lbits;
  logic [CNT48_W-1:0]    errs;

  assign berr  = out_tdata[OUT_BERR_LSB  +: BYTE_CNT_W];
  assign tbits = out_tdata[OUT_TBITS_LSB +: CNT48_W];
  assign lbits = out_tdata[OUT_LBITS_LSB +: CNT48_W];
  assign errs  = out_tdata[OUT_ERRS_LSB  +: CNT48_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // at most one error per bit of the byte
  a_berr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> berr <= BYTE_CNT_W'(BITS_PER_ITEM))
    else $error("byte error count out of range");

  // errors only counted on locked bits, locked bits are a subset of all bits
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (errs <= lbits) && (lbits <= tbits))
    else $error("counter ordering broken");

endmodule

bind prbs_sync_error_checker_unit psec_port_checker u_psec_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import psec_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_SETTLE   = 6;      // result register depth plus margin
  localparam int IDLE_PCT       = 31;
  localparam int PHASE_COUNT    = 10;
  localparam int FIXED_PHASES   = 8;
  localparam int PHASE_ITEMS    = 120;
  localparam int REPORT_LIMIT   = 10;
  localparam int STEADY_PHASE   = 2;
  localparam int DIRECTED_ROWS  = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

  // where a stimulus byte comes from
  typedef enum logic [1:0] {
    SRC_LITERAL,
    SRC_PRBS,
    SRC_PRBS_INV
  } byte_src_t;

  // one result transfer, split into its fields
  typedef struct packed {
    logic                  locked;
    logic [BYTE_CNT_W-1:0] err_bits;
    logic [CNT48_W-1:0]    bits_total;
    logic [CNT48_W-1:0]    bits_locked;
    logic [CNT48_W-1:0]    errors;
    logic [CNT32_W-1:0]    slips;
    logic                  last;
  } ber_stats_t;

  typedef struct packed {
    byte_src_t   src;
    logic [7:0]  data;
    logic        clr;
    logic        eob;
    logic        typed;   // want holds the result read off by hand
    ber_stats_t  want;
  } dir_row_t;

  typedef struct packed {
    logic [REG_W-1:0] seed;
    logic [REG_W-1:0] mask;
    logic [REG_W-1:0] taps;
    logic [REG_W-1:0] len;
  } lfsr_setup_t;

  // directed rows, run under the reset configuration (prbs7)
  dir_row_t dir_rows [DIRECTED_ROWS] = '{
    // all-zero byte straight after reset: 8 bits counted, far from lock
    '{SRC_LITERAL,  8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 4'd0, 48'd8, 48'd0, 48'd0, 32'd0, 1'b0}},
    // all-ones byte with clear and end of buffer: counters restart at this byte
    '{SRC_LITERAL,  8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 4'd0, 48'd8, 48'd0, 48'd0, 32'd0, 1'b1}},
    '{SRC_LITERAL,  8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_LITERAL,  8'h01, 1'b0, 1'b1, 1'b0, '0},
    // clean sequence until lock
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b1, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    // every bit wrong: eight errors per byte, then a slip
    '{SRC_PRBS_INV, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS_INV, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS_INV, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS_INV, 8'h00, 1'b0, 1'b1, 1'b0, '0},
    // relock
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_PRBS,     8'h00, 1'b0, 1'b0, 1'b0, '0},
    // clear while locked, then alternating patterns
    '{SRC_PRBS,     8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{SRC_LITERAL,  8'hAA, 1'b0, 1'b0, 1'b0, '0},
    '{SRC_LITERAL,  8'h55, 1'b0, 1'b1, 1'b0, '0}
  };

  // fixed phases: common prbs polynomials plus the length extremes
  lfsr_setup_t phase_setups [FIXED_PHASES] = '{
    '{64'h1,                  64'h7FFF,               64'h6000,               64'd15},
    '{64'h2468ACE,            64'h7FFF_FFFF,          64'h4800_0000,          64'd31},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hD800_0000_0000_0000, 64'd64},
    '{64'h0,                  64'h3,                  64'h3,                  64'd2},
    '{64'h55,                 64'h7F,                 64'h60,                 64'd0},
    '{64'h7F,                 64'h7F,                 64'h60,                 64'd127},
    '{64'h1FF,                64'h1FF,                64'h110,                64'd9},
    '{64'h3,                  64'h7F_FFFF,            64'h42_0000,            64'd23}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // rx_byte
  logic                  in_tuser = 1'b0; // clear_stats
  logic                  in_tlast = 1'b0; // end_of_buffer
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // is_locked, byte_error_bits, total_bits, locked_bits, total_errors, slip_count, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;       // end_of_buffer_out
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // checker copy: configuration
  logic [REG_W-1:0]   seed_m;
  logic [REG_W-1:0]   mask_m;
  logic [REG_W-1:0]   taps_m;
  logic [LEN_W-1:0]   len_m;
  // checker copy: state
  logic [REG_W-1:0]   lfsr_m;
  logic               lock_m;
  logic [SCORE_W-1:0] score_m;
  logic [CNT48_W-1:0] bits_m;
  logic [CNT48_W-1:0] lbits_m;
  logic [CNT48_W-1:0] errs_m;
  logic [CNT32_W-1:0] slips_m;

  // pattern source feeding the stimulus, same polynomial as the checker
  logic [REG_W-1:0]   prbs_src_m;

  ber_stats_t expected_stats_q [$];
  ber_stats_t oldest_stats;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       steady = 1'b0;      // no idling on either side while set

  prbs_sync_error_checker_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_stats_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (steady || !rst_n) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void reset_checker_model();
    seed_m  = SEED_RST;
    mask_m  = MASK_RST;
    taps_m  = TAPS_RST;
    len_m   = LEN_RST;
    lfsr_m  = SEED_RST;
    lock_m  = 1'b0;
    score_m = '0;
    bits_m  = '0;
    lbits_m = '0;
    errs_m  = '0;
    slips_m = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (cfg_index_t'(idx))
      CFG_SEED: begin
        seed_m = val;
        lfsr_m = val;   // seed load takes effect at once
      end
      CFG_MASK: mask_m = val;
      CFG_TAPS: taps_m = val;
      CFG_LEN:  len_m = val[LEN_W-1:0];
      default: ;      // unused indexes are ignored
    endcase
  endfunction

  // one byte through the checker, msb first; returns the result transfer it causes
  function automatic ber_stats_t check_byte_model(logic [7:0] rx, logic clr, logic eob);
    ber_stats_t            res;
    int                    thresh;
    int                    i;
    logic                  bit_in;
    logic                  pred;
    logic [BYTE_CNT_W-1:0] byte_errs;
    thresh    = int'(len_m) * 4;
    byte_errs = '0;
    if (clr) begin
      lock_m  = 1'b0;
      score_m = '0;
      bits_m  = '0;
      lbits_m = '0;
      errs_m  = '0;
      slips_m = '0;
    end
    for (i = 7; i >= 0; i--) begin
      bit_in = rx[i];
      pred   = ^(lfsr_m & taps_m);
      if (bits_m != '1) bits_m++;
      if (lock_m) begin
        // locked: register runs free on its own prediction
        if (lbits_m != '1) lbits_m++;
        lfsr_m = {lfsr_m[REG_W-2:0], pred};
        if (bit_in == pred) begin
          if (score_m != '0) score_m--;
        end else begin
          score_m++;
          if (errs_m != '1) errs_m++;
          byte_errs++;
        end
        if (int'(score_m) > thresh) begin
          score_m = '0;
          lock_m  = 1'b0;
          if (slips_m != '1) slips_m++;
        end
      end else begin
        // hunting: received bits load the register, count the match run
        lfsr_m = {lfsr_m[REG_W-2:0], bit_in};
        if (bit_in == pred) score_m++;
        else score_m = '0;
        if (int'(score_m) > thresh) begin
          score_m = '0;
          lock_m  = 1'b1;
        end
      end
      lfsr_m &= mask_m;
    end
    res.locked      = lock_m;
    res.err_bits    = byte_errs;
    res.bits_total  = bits_m;
    res.bits_locked = lbits_m;
    res.errors      = errs_m;
    res.slips       = slips_m;
    res.last        = eob;
    return res;
  endfunction

  // next byte of the pattern source, msb first
  function automatic logic [7:0] next_prbs_byte();
    logic [7:0] b;
    int         i;
    for (i = 7; i >= 0; i--) begin
      b[i]       = ^(prbs_src_m & taps_m);
      prbs_src_m = ((prbs_src_m << 1) | REG_W'(b[i])) & mask_m;
    end
    return b;
  endfunction

  function automatic logic [7:0] stimulus_byte(byte_src_t src, logic [7:0] lit);
    case (src)
      SRC_PRBS:     return next_prbs_byte();
      SRC_PRBS_INV: return ~next_prbs_byte();
      default:      return lit;
    endcase
  endfunction

  // offer one byte, wait for the transfer, then record what must come back
  task automatic send_byte(logic [7:0] b, logic clr, logic eob, logic typed,
                           ber_stats_t want);
    ber_stats_t pred;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= clr;
    in_tlast  <= eob;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = check_byte_model(b, clr, eob);
    expected_stats_q.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg_write(idx, val);
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic load_setup(lfsr_setup_t s);
    logic [CFG_DATA_W-1:0] len_word;
    // length word sometimes carries junk above the 7 used bits
    len_word = ($urandom_range(1) == 1) ? {$urandom, $urandom} : '0;
    len_word[LEN_W-1:0] = s.len[LEN_W-1:0];
    write_reg(CFG_LEN, len_word);
    write_reg(CFG_TAPS, s.taps);
    write_reg(CFG_MASK, s.mask);
    write_reg(CFG_SEED, s.seed);
    write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(3)), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // mostly clean pattern with sparse bit errors, plus inverted bursts, noise and resyncs
  task automatic run_phase(int items, int flip_permille);
    int         sent;
    int         sel;
    int         burst;
    int         i;
    logic [7:0] b;
    logic [7:0] flips;
    logic       clr;
    logic       eob;
    sent = 0;
    while (sent < items) begin
      if (sent == items / 2) wait_drain();
      sel   = $urandom_range(99);
      burst = 1;
      if (sel < 72) begin
        flips = '0;
        for (i = 0; i < 8; i++) flips[i] = ($urandom_range(999) < flip_permille);
        b = stimulus_byte(SRC_PRBS, 8'h00) ^ flips;
      end else if (sel < 80) begin
        burst = $urandom_range(1, 6);
        b = stimulus_byte(SRC_PRBS_INV, 8'h00);
      end else if (sel < 88) begin
        b = stimulus_byte(SRC_LITERAL, 8'($urandom_range(255)));
      end else if (sel < 92) begin
        b = stimulus_byte(SRC_LITERAL, ($urandom_range(1) == 1) ? 8'hFF : 8'h00);
      end else if (sel < 95) begin
        // source jumps to a new point of the sequence
        prbs_src_m = {$urandom, $urandom} & mask_m;
        b = stimulus_byte(SRC_PRBS, 8'h00);
      end else begin
        b = stimulus_byte(SRC_PRBS, 8'h00);
      end
      while (burst > 0 && sent < items) begin
        clr = ($urandom_range(99) < 3);
        eob = ($urandom_range(99) < 12);
        send_byte(b, clr, eob, 1'b0, '0);
        sent++;
        burst--;
        if (burst > 0) b = stimulus_byte(SRC_PRBS_INV, 8'h00);
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // result checker, in order against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stats_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result transfer with nothing expected: %0h", out_tdata);
      end else begin
        oldest_stats = expected_stats_q.pop_front();
        check_field("is_locked", 64'(oldest_stats.locked), 64'(out_tdata[OUT_LOCK_LSB]));
        check_field("byte_error_bits", 64'(oldest_stats.err_bits),
                    64'(out_tdata[OUT_BERR_LSB +: BYTE_CNT_W]));
        check_field("total_bits", 64'(oldest_stats.bits_total),
                    64'(out_tdata[OUT_TBITS_LSB +: CNT48_W]));
        check_field("locked_bits", 64'(oldest_stats.bits_locked),
                    64'(out_tdata[OUT_LBITS_LSB +: CNT48_W]));
        check_field("total_errors", 64'(oldest_stats.errors),
                    64'(out_tdata[OUT_ERRS_LSB +: CNT48_W]));
        check_field("slip_count", 64'(oldest_stats.slips),
                    64'(out_tdata[OUT_SLIP_LSB +: CNT32_W]));
        check_field("pad", 64'd0, 64'(out_tdata[OUT_DATA_W-1:OUT_USED_W]));
        check_field("end_of_buffer_out", 64'(oldest_stats.last), 64'(out_tlast));
      end
    end
  end

  // stimulus
  initial begin
    lfsr_setup_t s;
    int          p;
    int          r;
    reset_checker_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under reset configuration
    prbs_src_m = 64'h5A;
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      send_byte(stimulus_byte(dir_rows[r].src, dir_rows[r].data), dir_rows[r].clr,
                dir_rows[r].eob, dir_rows[r].typed, dir_rows[r].want);
    end
    wait_drain();

    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p < FIXED_PHASES) begin
        s = phase_setups[p];
      end else begin
        s.seed = {$urandom, $urandom};
        case ($urandom_range(2))
          0:       s.mask = '0;
          1:       s.mask = '1;
          default: s.mask = {$urandom, $urandom};
        endcase
        s.taps = ($urandom_range(3) == 0) ? '1 : {$urandom, $urandom};
        s.len  = REG_W'($urandom_range(127));
      end
      load_setup(s);
      prbs_src_m = {$urandom, $urandom} & mask_m;
      steady = (p == STEADY_PHASE);
      run_phase(PHASE_ITEMS, $urandom_range(20));
      wait_drain();
      steady = 1'b0;
    end

    if (mismatch_count == 0 && expected_stats_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/psec_pkg.sv
rtl/prbs_sync_error_checker_unit.sv
rtl/psec_port_checker.sv
tb/testbench.sv
